// ===== rtl/lpp_pkg.sv =====
package lpp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned SizeW  = 24;
  localparam int unsigned LimitW = 24;

  localparam logic [ByteW-1:0] SpaceChar = 8'h20;
  localparam logic [ByteW-1:0] DigitZero = 8'h30;
  localparam logic [ByteW-1:0] DigitNine = 8'h39;

  localparam logic [LimitW-1:0] LimitReset = 24'd65535;

  typedef enum logic [2:0] {
    PhMethod = 3'd0,
    PhHsize  = 3'd1,
    PhHeader = 3'd2,
    PhHsep   = 3'd3,
    PhBsize  = 3'd4,
    PhBody   = 3'd5,
    PhDone   = 3'd6,
    PhError  = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    KindNone   = 2'd0,
    KindMethod = 2'd1,
    KindHeader = 2'd2,
    KindBody   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    kind_e            field_kind;
    logic             field_end;
    logic [SizeW-1:0] size_value;
    logic             size_done;
    phase_e           phase;
  } result_t;

endpackage

// ===== rtl/lpp_byte_if.sv =====
interface lpp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// ===== rtl/lpp_result_if.sv =====
interface lpp_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [1:0]  field_kind;
  logic        field_end;
  logic [23:0] size_value;
  logic        size_done;
  logic [2:0]  phase;

  modport source (
    output valid, output data_byte, output field_kind, output field_end,
    output size_value, output size_done, output phase, input ready
  );
  modport sink (
    input valid, input data_byte, input field_kind, input field_end,
    input size_value, input size_done, input phase, output ready
  );
endinterface

// ===== rtl/length_prefixed_request_parser.sv =====
// length-prefixed request parser
// in_i carries one raw request byte per beat; out_o returns one tagged beat
// per input beat: data byte, field kind, field end, parsed length with its
// done flag, and the parse phase after that byte
// max_field_length_we_i / max_field_length_i load the length limit; write it
// only while no beat is in flight
// latency: a byte accepted at one edge shows on out_o after that edge,
// one cycle later
// throughput: one byte per cycle; the parse state and the output register
// both update at the accepting edge, so bytes may follow back to back
// stall: the output register holds its beat while out_o.ready is low, and
// in_i.ready drops only while that register is full and not draining
// reset: phase goes to method, the length accumulator and remaining count
// clear, the limit returns to 65535 and out_o goes empty
// after complete or error every byte yields a beat with only phase set,
// until the next reset
module length_prefixed_request_parser #(
  parameter int unsigned LENGTH_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         max_field_length_we_i,
  input  logic [lpp_pkg::LimitW-1:0]   max_field_length_i,
  lpp_byte_if.sink                     in_i,
  lpp_result_if.source                 out_o
);

  lpp_pkg::phase_e              phase_q;
  lpp_pkg::phase_e              phase_d;
  logic [LENGTH_BITS-1:0]       acc_q;
  logic [LENGTH_BITS-1:0]       acc_d;
  logic                         seen_q;
  logic                         seen_d;
  logic [LENGTH_BITS-1:0]       rem_q;
  logic [LENGTH_BITS-1:0]       rem_d;
  logic [lpp_pkg::LimitW-1:0]   limit_q;
  lpp_pkg::result_t             res;
  logic                         free;
  logic                         fire;

  assign in_i.ready = free;
  assign fire       = in_i.valid && free;

  lpp_step #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_step (
    .phase_i (phase_q),
    .acc_i   (acc_q),
    .seen_i  (seen_q),
    .rem_i   (rem_q),
    .byte_i  (in_i.in_byte),
    .limit_i (limit_q),
    .phase_o (phase_d),
    .acc_o   (acc_d),
    .seen_o  (seen_d),
    .rem_o   (rem_d),
    .res_o   (res)
  );

  lpp_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (fire),
    .res_i  (res),
    .free_o (free),
    .out_o  (out_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lpp_pkg::PhMethod;
      acc_q   <= '0;
      seen_q  <= 1'b0;
      rem_q   <= '0;
    end else if (fire) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      seen_q  <= seen_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= lpp_pkg::LimitReset;
    end else if (max_field_length_we_i) begin
      limit_q <= max_field_length_i;
    end
  end

endmodule

// ===== rtl/lpp_step.sv =====
module lpp_step #(
  parameter int unsigned LENGTH_BITS = 24
) (
  input  lpp_pkg::phase_e                  phase_i,
  input  logic [LENGTH_BITS-1:0]           acc_i,
  input  logic                             seen_i,
  input  logic [LENGTH_BITS-1:0]           rem_i,
  input  logic [lpp_pkg::ByteW-1:0]        byte_i,
  input  logic [lpp_pkg::LimitW-1:0]       limit_i,
  output lpp_pkg::phase_e                  phase_o,
  output logic [LENGTH_BITS-1:0]           acc_o,
  output logic                             seen_o,
  output logic [LENGTH_BITS-1:0]           rem_o,
  output lpp_pkg::result_t                 res_o
);

  localparam int unsigned VW = LENGTH_BITS + 4;
  localparam int unsigned CW = (VW > lpp_pkg::LimitW) ? VW : lpp_pkg::LimitW;

  logic [VW-1:0]                          acc_x10;
  logic                                   over;
  logic [LENGTH_BITS-1:0]                 rem_dec;
  logic [LENGTH_BITS+lpp_pkg::SizeW-1:0]  acc_ext;
  logic                                   is_hdr;

  // acc*10 + digit, checked against the register limit and the width cap
  assign acc_x10 = (VW'(acc_i) << 3) + (VW'(acc_i) << 1) + VW'(byte_i[3:0]);
  assign over    = (CW'(acc_x10) > CW'(limit_i)) || (acc_x10[VW-1:LENGTH_BITS] != '0);
  assign rem_dec = (rem_i != '0) ? rem_i - LENGTH_BITS'(1) : rem_i;
  assign acc_ext = {{lpp_pkg::SizeW{1'b0}}, acc_i};

  always_comb begin
    phase_o = phase_i;
    acc_o   = acc_i;
    seen_o  = seen_i;
    rem_o   = rem_i;
    is_hdr  = 1'b0;
    res_o   = '0;
    case (phase_i)
      lpp_pkg::PhMethod: begin
        res_o.field_kind = lpp_pkg::KindMethod;
        if (byte_i == lpp_pkg::SpaceChar) begin
          res_o.field_end = 1'b1;
          phase_o         = lpp_pkg::PhHsize;
          acc_o           = '0;
          seen_o          = 1'b0;
        end else begin
          res_o.data_byte = byte_i;
        end
      end
      lpp_pkg::PhHsize, lpp_pkg::PhBsize: begin
        is_hdr = (phase_i == lpp_pkg::PhHsize);
        if (byte_i inside {[lpp_pkg::DigitZero:lpp_pkg::DigitNine]}) begin
          if (over) begin
            phase_o = lpp_pkg::PhError;
          end else begin
            acc_o  = acc_x10[LENGTH_BITS-1:0];
            seen_o = 1'b1;
          end
        end else if (byte_i == lpp_pkg::SpaceChar && seen_i) begin
          res_o.size_value = acc_ext[lpp_pkg::SizeW-1:0];
          res_o.size_done  = 1'b1;
          rem_o            = acc_i;
          if (acc_i != '0) begin
            phase_o = is_hdr ? lpp_pkg::PhHeader : lpp_pkg::PhBody;
          end else begin
            phase_o = is_hdr ? lpp_pkg::PhHsep : lpp_pkg::PhDone;
          end
          acc_o  = '0;
          seen_o = 1'b0;
        end else begin
          phase_o = lpp_pkg::PhError;
        end
      end
      lpp_pkg::PhHeader, lpp_pkg::PhBody: begin
        is_hdr           = (phase_i == lpp_pkg::PhHeader);
        res_o.data_byte  = byte_i;
        res_o.field_kind = is_hdr ? lpp_pkg::KindHeader : lpp_pkg::KindBody;
        rem_o            = rem_dec;
        if (rem_dec == '0) begin
          res_o.field_end = 1'b1;
          phase_o         = is_hdr ? lpp_pkg::PhHsep : lpp_pkg::PhDone;
        end
      end
      lpp_pkg::PhHsep: begin
        phase_o = lpp_pkg::PhBsize;
        acc_o   = '0;
        seen_o  = 1'b0;
      end
      default: begin
      end
    endcase
    res_o.phase = phase_o;
  end

endmodule

// ===== rtl/lpp_out_stage.sv =====
module lpp_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  lpp_pkg::result_t res_i,
  output logic             free_o,
  lpp_result_if.source     out_o
);

  logic             valid_q;
  logic             valid_d;
  lpp_pkg::result_t res_q;

  // slot can take a new beat when empty or draining this cycle
  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.data_byte  = res_q.data_byte;
  assign out_o.field_kind = res_q.field_kind;
  assign out_o.field_end  = res_q.field_end;
  assign out_o.size_value = res_q.size_value;
  assign out_o.size_done  = res_q.size_done;
  assign out_o.phase      = res_q.phase;

endmodule
